// ===== hdl/sha256_byte_stream_hasher_defines.svh =====
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Assertion helpers used by the controller. They compile to nothing when
// SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTH
// check a consequent in the same cycle as its antecedent
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sha256 hasher: assertion failed");
// check a consequent in the cycle after its antecedent
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sha256 hasher: assertion failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher package
// Constants, round table, controller and datapath types, and the SHA-256
// sigma functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

	localparam int unsigned WORD_W = 32;

	// fill position of the last byte of a block, and where the length starts
	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam logic [5:0] ROUND_LAST  = 6'd63;
	localparam logic [2:0] IDX_LAST    = 3'd7;
	localparam logic [63:0] LEN_STEP   = 64'd8;
	localparam logic [7:0] PAD_MARK    = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// controller states
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PAD   = 6'b000010,
		S_INIT  = 6'b000100,
		S_ROUND = 6'b001000,
		S_ADDH  = 6'b010000,
		S_EMIT  = 6'b100000
	} ctrl_state_t;

	// source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		SRC_MSG  = 2'd0,
		SRC_MARK = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	typedef struct packed {
		logic        absorb;
		byte_src_t   src;
		logic        len_add;
		logic        load_v;
		logic        round;
		logic [5:0]  rnd;
		logic        add_h;
		logic        restart;
		logic [2:0]  word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} dp_stat_t;

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== hdl/sha_ifs.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher channel interfaces
// Byte input channel and digest word output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha_byte_if;
	import sha_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_valid;
	logic       msg_end;

	modport source (output valid, output msg_byte, output byte_valid, output msg_end,
		input ready);
	modport sink (input valid, input msg_byte, input byte_valid, input msg_end,
		output ready);
endinterface

interface sha_word_if;
	import sha_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [2:0]        word_index;
	logic              last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== hdl/sha256_byte_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the eight digest words of each message.
// ---------------------------------------------------------------------------
// Usage:
//   msg_chan takes one beat per message byte (byte_valid = 1) and/or an end
//   mark (msg_end = 1). A beat with neither is taken and ignored.
//   digest_chan returns eight beats per message, H0 first, word_index 0 to 7,
//   last_word set on the eighth.
// Timing:
//   The 64th byte of a block starts a compression: a load step, 64 rounds
//   (one round per cycle in the shared round unit) and an add step, with
//   msg_chan not ready throughout. At the end mark, padding bytes go into
//   the buffer one per cycle, then one or two compressions follow before
//   the first digest beat. No bytes are taken while a block is being
//   compressed.
// Reset and stalls:
//   Reset loads the initial hash, clears the length and fill count and
//   returns to intake. While digest_chan is stalled the current word holds
//   and msg_chan stays not ready until the eighth beat is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
	input logic         clk,
	input logic         arst_n,
	sha_byte_if.sink    msg_chan,
	sha_word_if.source  digest_chan
);
	import sha_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (msg_chan.valid),
		.in_byte_valid (msg_chan.byte_valid),
		.in_msg_end    (msg_chan.msg_end),
		.in_ready      (msg_chan.ready),
		.out_valid     (digest_chan.valid),
		.out_ready     (digest_chan.ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_byte    (msg_chan.msg_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_chan.digest_word),
		.word_index  (digest_chan.word_index),
		.last_word   (digest_chan.last_word)
	);

endmodule

// ===== hdl/sha_ctrl.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher controller
// Sequences byte intake, padding, the 64 compression rounds and the digest
// beats; drives the datapath by command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_defines.svh"

module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_byte_valid,
	input  logic              in_msg_end,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sha_pkg::dp_stat_t stat,
	output sha_pkg::dp_cmd_t  cmd
);
	import sha_pkg::*;

	ctrl_state_t state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        end_pend_q;
	logic        first_q;
	logic        len_ok_q;
	logic        len_done_q;

	// decode commands from state
	always_comb begin
		cmd          = '0;
		cmd.src      = SRC_ZERO;
		cmd.rnd      = rnd_q;
		cmd.word_idx = idx_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.src     = SRC_MSG;
				cmd.absorb  = in_valid && in_byte_valid;
				cmd.len_add = in_valid && in_byte_valid;
			end
			S_PAD: begin
				cmd.absorb = 1'b1;
				if (first_q) begin
					cmd.src = SRC_MARK;
				end else if (len_ok_q && stat.fill >= PAD_LEN_POS) begin
					cmd.src = SRC_LEN;
				end else begin
					cmd.src = SRC_ZERO;
				end
			end
			S_INIT: begin
				cmd.load_v = 1'b1;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
			end
			S_ADDH: begin
				cmd.add_h = 1'b1;
			end
			S_EMIT: begin
				out_valid   = 1'b1;
				cmd.restart = out_ready && idx_q == IDX_LAST;
			end
			default: begin
				cmd.src = SRC_ZERO;
			end
		endcase
	end

	// advance state and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rnd_q      <= '0;
			idx_q      <= '0;
			end_pend_q <= 1'b0;
			first_q    <= 1'b0;
			len_ok_q   <= 1'b0;
			len_done_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						end_pend_q <= in_msg_end;
						first_q    <= 1'b1;
						len_ok_q   <= 1'b0;
						if (in_byte_valid && stat.fill == FILL_LAST) begin
							state_q <= S_INIT;
						end else if (in_msg_end) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					// the length fits behind the mark only if the mark lands before it
					if (first_q) begin
						first_q  <= 1'b0;
						len_ok_q <= stat.fill < PAD_LEN_POS;
					end
					if (stat.fill == FILL_LAST) begin
						len_done_q <= !first_q && len_ok_q;
						state_q    <= S_INIT;
					end
				end
				S_INIT: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == ROUND_LAST) begin
						state_q <= S_ADDH;
					end
				end
				S_ADDH: begin
					if (len_done_q) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else if (end_pend_q) begin
						len_ok_q <= 1'b1;
						state_q  <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == IDX_LAST) begin
							end_pend_q <= 1'b0;
							len_done_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SHA_ASSERT_NXT(a_round_end, clk, arst_n, state_q == S_ROUND && rnd_q == ROUND_LAST, state_q == S_ADDH)
	`SHA_ASSERT_NXT(a_full_block, clk, arst_n, state_q == S_IDLE && in_valid && in_byte_valid && stat.fill == FILL_LAST, state_q == S_INIT)
	`SHA_ASSERT_NXT(a_emit_entry, clk, arst_n, state_q == S_ADDH && len_done_q, state_q == S_EMIT && idx_q == 3'd0)
	`SHA_ASSERT_NXT(a_emit_done, clk, arst_n, state_q == S_EMIT && out_ready && idx_q == IDX_LAST, state_q == S_IDLE && idx_q == 3'd0 && !len_done_q && stat.fill == 6'd0)

endmodule

// ===== hdl/sha_dp.sv =====
// ---------------------------------------------------------------------------
// SHA-256 hasher datapath
// Block buffer that doubles as the rolling message schedule, working
// variables, chaining value, bit length and fill count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    msg_byte,
	input  sha_pkg::dp_cmd_t              cmd,
	output sha_pkg::dp_stat_t             stat,
	output logic [sha_pkg::WORD_W-1:0]    digest_word,
	output logic [2:0]                    word_index,
	output logic                          last_word
);
	import sha_pkg::*;

	logic [31:0] blk_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [63:0] len_q;
	logic [5:0]  fill_q;

	logic [7:0]  byte_d;
	logic [2:0]  len_k;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	// select the byte to shift in
	assign len_k = fill_q[2:0];
	always_comb begin
		case (cmd.src)
			SRC_MSG:  byte_d = msg_byte;
			SRC_MARK: byte_d = PAD_MARK;
			SRC_LEN:  byte_d = len_q[{~len_k, 3'b000} +: 8];
			default:  byte_d = 8'h00;
		endcase
	end

	// one round: next schedule word and the two temporaries
	always_comb begin
		w_new = small_sig1(blk_q[14]) + blk_q[9] + small_sig0(blk_q[1]) + blk_q[0];
		t1    = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[cmd.rnd] + blk_q[0];
		t2    = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// shift bytes in, or roll the schedule one word per round
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			end
			blk_q[15] <= {blk_q[15][23:0], byte_d};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[15] <= w_new;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chaining value, bit length and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_HASH[i];
			end
			len_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.absorb) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.len_add) begin
				len_q <= len_q + LEN_STEP;
			end
			if (cmd.add_h) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= INIT_HASH[i];
				end
				len_q  <= '0;
				fill_q <= '0;
			end
		end
	end

	assign stat.fill   = fill_q;
	assign digest_word = h_q[cmd.word_idx];
	assign word_index  = cmd.word_idx;
	assign last_word   = cmd.word_idx == IDX_LAST;

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives message bytes and end marks into the hasher. A scoreboard hashes the
// same beats in software and checks each digest word in order, field by field.
// A short directed run comes first, then random messages, some with lengths
// near the padding boundaries, under three phases of sender and receiver idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned ITEM_TARGET = 470;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 250;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LEN_FIELD_POS = 56;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	// software hasher and store of pending digest words
	class digest_scoreboard;
		logic [31:0]  chain [8];
		logic [7:0]   blk_bytes [64];
		int unsigned  fill;
		logic [63:0]  bit_len;
		digest_beat_t want_q [$];
		int unsigned  error_count;

		function new();
			error_count = 0;
			restart();
		endfunction

		function void restart();
			int i;
			for (i = 0; i < 8; i++) begin
				chain[i] = HASH_IV[i];
			end
			fill = 0;
			bit_len = '0;
		endfunction

		function logic [31:0] ror(input logic [31:0] x, input int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// run the 64 rounds over the buffered block
		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] s0, s1, t1, t2;
			int i;
			for (i = 0; i < 16; i++) begin
				w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
			end
			for (i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			for (i = 0; i < 8; i++) begin
				v[i] = chain[i];
			end
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_CONST[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++) begin
				chain[i] = chain[i] + v[i];
			end
		endfunction

		function void absorb(input logic [7:0] b);
			blk_bytes[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		// take one accepted input beat; on an end mark pad and queue the digest
		function void note_beat(input logic [7:0] b, input logic bv, input logic e);
			logic [63:0] len;
			digest_beat_t beat;
			int i;
			if (bv) begin
				absorb(b);
				bit_len = bit_len + 64'd8;
			end
			if (!e) begin
				return;
			end
			len = bit_len;
			absorb(PAD_BYTE);
			while (fill != LEN_FIELD_POS) begin
				absorb(8'h00);
			end
			for (i = 0; i < 8; i++) begin
				absorb(len[63 - 8*i -: 8]);
			end
			for (i = 0; i < 8; i++) begin
				beat.word = chain[i];
				beat.idx = i[2:0];
				beat.last = (i == 7);
				want_q.push_back(beat);
			end
			restart();
		endfunction

		// compare one accepted digest beat with the oldest pending word
		function void check_word(input logic [31:0] word, input logic [2:0] idx,
				input logic last);
			digest_beat_t want;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected digest beat word=%h index=%0d last=%0b",
					$time, word, idx, last);
				error_count++;
				return;
			end
			want = want_q.pop_front();
			if (word !== want.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, want.word, word);
				error_count++;
			end
			if (idx !== want.idx) begin
				$display("%0t: word_index expected %0d actual %0d", $time, want.idx, idx);
				error_count++;
			end
			if (last !== want.last) begin
				$display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
				error_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned items_sent;
	int unsigned cycle_count;
	digest_scoreboard sb;

	sha_byte_if msg_chan();
	sha_word_if digest_chan();

	sha256_byte_stream_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_chan    (msg_chan),
		.digest_chan (digest_chan)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = ~clk;
		end
	end

	// abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// check digest beats and stall the receiver at random
	always @(posedge clk) begin
		if (digest_chan.valid && digest_chan.ready) begin
			sb.check_word(digest_chan.digest_word, digest_chan.word_index,
				digest_chan.last_word);
		end
		digest_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// present one beat, idling the sender at random, and hold until taken
	task automatic send_beat(input logic [7:0] b, input logic bv, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_chan.valid <= 1'b0;
			@(posedge clk);
		end
		msg_chan.valid <= 1'b1;
		msg_chan.msg_byte <= b;
		msg_chan.byte_valid <= bv;
		msg_chan.msg_end <= e;
		@(posedge clk);
		while (!msg_chan.ready) begin
			@(posedge clk);
		end
		sb.note_beat(b, bv, e);
		if (bv || e) begin
			items_sent++;
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// send one message with random content, stray idle beats and its end mark
	task automatic send_message(input int unsigned n_bytes);
		logic joined;
		int unsigned k;
		joined = (n_bytes != 0) && ($urandom_range(1) == 1);
		for (k = 0; k < n_bytes; k++) begin
			if ($urandom_range(19) == 0) begin
				send_beat(8'($urandom), 1'b0, 1'b0);
			end
			send_beat(pick_byte(), 1'b1, joined && (k == n_bytes - 1));
		end
		if (!joined) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// lengths are mostly short, some around the one- and two-block padding boundaries
	function automatic int unsigned pick_length();
		case ($urandom_range(9))
			0: return $urandom_range(3);
			1: return $urandom_range(57, 52);
			2: return $urandom_range(66, 60);
			3: return $urandom_range(122, 115);
			default: return $urandom_range(40);
		endcase
	endfunction

	initial begin
		sb = new();
		items_sent = 0;
		send_idle_pct = 8;
		recv_stall_pct = 88;
		arst_n <= 1'b0;
		msg_chan.valid <= 1'b0;
		msg_chan.msg_byte <= 8'h00;
		msg_chan.byte_valid <= 1'b0;
		msg_chan.msg_end <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, with an idle beat after it
		send_beat(8'h5A, 1'b0, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b0);
		// three bytes, end mark on the last byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// extremes and the pad value as data, idle inside, separate end mark
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b0);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		// single-byte messages at both extremes
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);

		// random messages under three idling phases
		while (items_sent < ITEM_TARGET) begin
			if (items_sent < ITEM_TARGET / 3) begin
				send_idle_pct = 8;
				recv_stall_pct = 88;
			end else if (items_sent < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 88;
				recv_stall_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			send_message(pick_length());
		end
		msg_chan.valid <= 1'b0;

		// drain the pending digest words, then watch for stray beats
		while (sb.want_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_ifs.sv
hdl/sha_ctrl.sv
hdl/sha_dp.sv
hdl/sha256_byte_stream_hasher.sv
bench/testbench.sv
